FILE: hdl/wavhp_pkg.sv
// Package for the WAV header parser: transaction and result types,
// status and sample format codes, and the RIFF chunk tags.
// Has no dependencies; every other file of the block imports it.
package wavhp_pkg;

    localparam int OUT_DATA_W = 120;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BROKEN      = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic [1:0] SF_NONE  = 2'd0;
    localparam logic [1:0] SF_S16   = 2'd1;
    localparam logic [1:0] SF_S24   = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] PCM_TAG    = 16'd1;
    localparam logic [31:0] FMT_MIN_SZ = 32'd16;
    localparam logic [15:0] DEPTH_16   = 16'd16;
    localparam logic [15:0] DEPTH_24   = 16'd24;

    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [32:0] data_end;
        logic [12:0] data_begin;
        logic [1:0]  sample_format;
        logic [15:0] bits_per_sample;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [1:0]  parse_status;
    } t_result;

endpackage

FILE: hdl/wavhp_in_stage.sv
// Input register of the WAV header parser: holds one accepted byte
// until the parse stage takes it. Depends on wavhp_pkg.
module wavhp_in_stage
    import wavhp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hdl/wavhp_parse.sv
// Parse stage of the WAV header parser: the byte counter, chunk walker
// and captured fmt fields, updated once per byte. Depends on wavhp_pkg.
module wavhp_parse
    import wavhp_pkg::*;
#(
    parameter int WINDOW_BYTES  = 4096,
    parameter int SEARCH_MARGIN = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_emit,
    output t_result o_result
);

    localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
    localparam int CS_W  = $clog2(WINDOW_BYTES);

    localparam logic [2:0] PH_HEADER      = 3'd0;
    localparam logic [2:0] PH_FMT_SEARCH  = 3'd1;
    localparam logic [2:0] PH_FMT_BODY    = 3'd2;
    localparam logic [2:0] PH_DATA_SEARCH = 3'd3;
    localparam logic [2:0] PH_DATA_SIZE   = 3'd4;
    localparam logic [2:0] PH_DONE        = 3'd5;

    localparam logic [CNT_W-1:0] WIN       = CNT_W'(WINDOW_BYTES);
    localparam logic [CNT_W-1:0] FMT_LIM   = CNT_W'(WINDOW_BYTES - 23);
    localparam logic [CNT_W-1:0] DATA_LIM  = CNT_W'(WINDOW_BYTES - 7);
    localparam logic [CNT_W-1:0] SRCH_LIM  = CNT_W'(WINDOW_BYTES - SEARCH_MARGIN);
    localparam logic [33:0]      NEXT_LIM  = 34'(WINDOW_BYTES - 11);
    localparam logic [CS_W-1:0]  FIRST_CS  = CS_W'(12);

    logic [CNT_W-1:0] r_count,  n_count,  c_count;
    logic [CS_W-1:0]  r_cs,     n_cs,     c_cs;
    logic [2:0]       r_phase,  n_phase,  c_phase;
    logic [31:0]      r_tag,    n_tag,    c_tag;
    logic [31:0]      r_size,   n_size,   c_size;
    logic [15:0]      r_chan,   n_chan,   c_chan;
    logic [31:0]      r_rate,   n_rate,   c_rate;
    logic [15:0]      r_depth,  n_depth,  c_depth;

    logic [7:0]       b;
    logic [31:0]      tag_next, size_next;
    logic [CNT_W-1:0] cs_ext, rel;
    logic [33:0]      chunk_sum, begin_w, end_w;
    logic             fin;
    logic             full;
    logic [1:0]       status, fmt;

    assign b        = i_item.data;
    assign c_count  = i_item.first ? '0        : r_count;
    assign c_cs     = i_item.first ? FIRST_CS  : r_cs;
    assign c_phase  = i_item.first ? PH_HEADER : r_phase;
    assign c_tag    = i_item.first ? '0        : r_tag;
    assign c_size   = i_item.first ? '0        : r_size;
    assign c_chan   = i_item.first ? '0        : r_chan;
    assign c_rate   = i_item.first ? '0        : r_rate;
    assign c_depth  = i_item.first ? '0        : r_depth;

    assign tag_next  = {b, c_tag[31:8]};
    assign size_next = {b, c_size[31:8]};
    assign cs_ext    = CNT_W'(c_cs);
    assign rel       = c_count - cs_ext;
    assign chunk_sum = 34'(c_cs) + 34'(size_next);
    assign begin_w   = 34'(c_cs) + 34'd8;
    assign end_w     = begin_w + 34'(size_next);

    always_comb begin
        n_count = c_count;
        n_cs    = c_cs;
        n_phase = c_phase;
        n_tag   = c_tag;
        n_size  = c_size;
        n_chan  = c_chan;
        n_rate  = c_rate;
        n_depth = c_depth;
        fin     = 1'b0;
        full    = 1'b0;
        status  = ST_BROKEN;
        fmt     = SF_NONE;

        if (c_phase != PH_DONE) begin
            if (c_count < WIN) begin
                n_count = c_count + CNT_W'(1);
            end
            if (c_count >= WIN) begin
                fin = 1'b1;
            end else begin
                unique case (c_phase)
                    PH_HEADER: begin
                        n_tag = tag_next;
                        if (c_count == CNT_W'(3) && tag_next != TAG_RIFF) begin
                            fin = 1'b1;
                        end
                        if (c_count == CNT_W'(11)) begin
                            if (tag_next != TAG_WAVE) begin
                                fin = 1'b1;
                            end else begin
                                n_phase = PH_FMT_SEARCH;
                                n_cs    = FIRST_CS;
                            end
                        end
                    end
                    PH_FMT_SEARCH, PH_DATA_SEARCH: begin
                        if (c_count >= cs_ext) begin
                            if (rel < CNT_W'(4)) begin
                                n_tag = tag_next;
                                if (rel == CNT_W'(3)) begin
                                    if (c_phase == PH_FMT_SEARCH && tag_next == TAG_FMT) begin
                                        if (cs_ext >= FMT_LIM) begin
                                            fin = 1'b1;
                                        end
                                        n_phase = PH_FMT_BODY;
                                    end else if (c_phase == PH_DATA_SEARCH &&
                                                 tag_next == TAG_DATA) begin
                                        if (cs_ext >= DATA_LIM) begin
                                            fin = 1'b1;
                                        end
                                        n_phase = PH_DATA_SIZE;
                                    end else if (cs_ext >= SRCH_LIM) begin
                                        fin = 1'b1;
                                    end
                                end
                            end else if (rel < CNT_W'(8)) begin
                                n_size = size_next;
                                if (rel == CNT_W'(7)) begin
                                    if (chunk_sum >= NEXT_LIM) begin
                                        fin = 1'b1;
                                    end
                                    n_cs = CS_W'(chunk_sum + 34'd8);
                                end
                            end
                        end
                    end
                    PH_FMT_BODY: begin
                        if (c_count >= cs_ext) begin
                            if (rel >= CNT_W'(4) && rel < CNT_W'(8)) begin
                                n_size = size_next;
                            end else if (rel == CNT_W'(8) || rel == CNT_W'(9)) begin
                                n_tag = tag_next;
                                if (rel == CNT_W'(9) && tag_next[31:16] != PCM_TAG) begin
                                    fin    = 1'b1;
                                    status = ST_UNSUPPORTED;
                                end
                            end else if (rel == CNT_W'(10) || rel == CNT_W'(11)) begin
                                n_chan = {b, c_chan[15:8]};
                            end else if (rel >= CNT_W'(12) && rel < CNT_W'(16)) begin
                                n_rate = {b, c_rate[31:8]};
                            end else if (rel == CNT_W'(22) || rel == CNT_W'(23)) begin
                                n_depth = {b, c_depth[15:8]};
                                if (rel == CNT_W'(23)) begin
                                    if (c_size < FMT_MIN_SZ) begin
                                        fin = 1'b1;
                                    end else if (34'(c_cs) + 34'(c_size) >= NEXT_LIM) begin
                                        fin = 1'b1;
                                    end
                                    n_cs    = CS_W'(34'(c_cs) + 34'(c_size) + 34'd8);
                                    n_phase = PH_DATA_SEARCH;
                                end
                            end
                        end
                    end
                    PH_DATA_SIZE: begin
                        if (c_count >= cs_ext && rel >= CNT_W'(4) && rel < CNT_W'(8)) begin
                            n_size = size_next;
                            if (rel == CNT_W'(7)) begin
                                fin  = 1'b1;
                                full = 1'b1;
                                if (c_depth == DEPTH_16) begin
                                    status = ST_OK;
                                    fmt    = SF_S16;
                                end else if (c_depth == DEPTH_24) begin
                                    status = ST_OK;
                                    fmt    = SF_S24;
                                end else begin
                                    status = ST_UNSUPPORTED;
                                end
                            end
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            if (fin) begin
                n_phase = PH_DONE;
            end
        end
    end

    assign o_emit = i_valid && fin;

    always_comb begin
        o_result               = '0;
        o_result.parse_status  = status;
        if (full) begin
            o_result.channel_count   = c_chan;
            o_result.sample_rate     = c_rate;
            o_result.bits_per_sample = c_depth;
            o_result.sample_format   = fmt;
            o_result.data_begin      = begin_w[12:0];
            o_result.data_end        = end_w[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cs    <= FIRST_CS;
            r_phase <= PH_HEADER;
            r_tag   <= '0;
            r_size  <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_depth <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_cs    <= n_cs;
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_size  <= n_size;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_depth <= n_depth;
        end
    end

endmodule

FILE: hdl/wav_header_parser_unit.sv
// Top level of the WAV header parser: input register, parse stage and
// result register. Depends on wavhp_pkg, wavhp_in_stage and wavhp_parse.
//
// The slave stream carries a WAV file one byte per transaction, and
// tuser bit 0 marks the byte at file offset zero, which restarts the parse.
// The master stream carries one result transaction per parse: status,
// fmt fields, data chunk offsets and the sample format.
// Each byte is registered at acceptance and runs through the parse logic
// from the input register; a result it causes is registered in the result
// register at the master side. One byte per cycle is sustained except in
// the stall below; the limit is the per-byte update of the parse state.
// After reset the parse waits for offset zero, and the first byte counts as
// offset zero even without the tuser mark. While a result waits for the
// receiver, bytes that decide nothing keep flowing; a byte that would cause
// a new result is held in the input register, which then stops the slave
// side. Bytes after a result are dropped until the next offset-zero mark.
module wav_header_parser_unit
    import wavhp_pkg::*;
#(
    parameter int WINDOW_BYTES  = 4096,
    parameter int SEARCH_MARGIN = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // file_byte
    input  logic [0:0]            i_s_axis_tuser,  // first_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // parse_status, channel_count, sample_rate, bits_per_sample,
    // sample_format, data_begin, data_end, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_item   in_item, held_item;
    logic    held_valid, step, emit;
    t_result result;
    logic    r_out_valid;
    t_result r_out;

    assign in_item.first = i_s_axis_tuser[0];
    assign in_item.data  = i_s_axis_tdata;

    wavhp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    wavhp_parse #(
        .WINDOW_BYTES  (WINDOW_BYTES),
        .SEARCH_MARGIN (SEARCH_MARGIN)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .i_step   (step),
        .i_item   (held_item),
        .o_emit   (emit),
        .o_result (result)
    );

    assign step = held_valid && (!emit || !r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_out};

    a_broken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.parse_status == ST_BROKEN) |->
        (r_out.channel_count == '0 && r_out.sample_rate == '0 &&
         r_out.data_begin == '0 && r_out.data_end == '0))
        else $error("broken header result carries nonzero fields");

    a_format_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sample_format != SF_NONE) |->
        (r_out.parse_status == ST_OK))
        else $error("sample format set on a failed parse");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (held_valid && emit && r_out_valid))
        else $error("slave side stalled without a pending result");

endmodule
